@@ design/fcpa_pkg.sv @@
// Shared types, codes and helper functions for the chunk pool allocator.
package fcpa_pkg;

  localparam int DEF_POOL_DEPTH = 256;
  localparam int CNT_W          = 9;
  localparam int BYTES_W        = 17;
  localparam int SIZE_W         = 17;
  localparam int ALIGN_W        = 7;
  localparam int FIDX_W         = 8;
  localparam int OIDX_W         = 8;
  localparam int OFFSET_W       = 24;
  localparam int STATUS_W       = 3;
  localparam int CFG_IDX_W      = 1;
  localparam int CFG_DATA_W     = 17;

  localparam logic [CNT_W-1:0]   RST_CHUNK_COUNT = 9'd256;
  localparam logic [BYTES_W-1:0] RST_CHUNK_BYTES = 17'd64;
  localparam logic [BYTES_W-1:0] MAX_CHUNK_BYTES = 17'd65536;
  localparam logic [ALIGN_W-1:0] MAX_ALIGN       = 7'd8;

  typedef enum logic [1:0] {
    OP_ALLOC = 2'd0,
    OP_FREE  = 2'd1,
    OP_RESET = 2'd2,
    OP_NOP   = 2'd3
  } op_e_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_NO_MEM    = 3'd1,
    ST_TOO_BIG   = 3'd2,
    ST_BAD_ALIGN = 3'd3,
    ST_BAD_INDEX = 3'd4
  } status_e_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CHUNK_COUNT = 1'b0,
    CFG_CHUNK_BYTES = 1'b1
  } cfg_idx_e_t;

  typedef enum logic [1:0] {
    S_SWEEP,
    S_IDLE,
    S_ALLOC
  } state_e_t;

  // controller -> datapath
  typedef struct packed {
    logic      rd_issue;     // allocate passes checks: read head link, start offset multiply
    logic      alloc_done;   // link data back: pop head, load granted result
    logic      free_push;    // push free index onto the list
    logic      sweep_start;  // begin relinking pass
    logic      sweep_step;   // write one link entry of the pass
    logic      resp_load;    // load a non-granting result
    status_e_t resp_status;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic size_bad;
    logic align_bad;
    logic empty;
    logic fidx_bad;
    logic sweep_last;
    logic out_busy;
  } stat_t;

  // chunk_count of zero acts as one, above the pool depth saturates
  function automatic logic [CNT_W-1:0] eff_count(logic [CNT_W-1:0] raw, int unsigned depth);
    logic [CNT_W-1:0] n;
    n = raw;
    if (raw == '0) begin
      n = CNT_W'(1);
    end else if (32'(raw) > depth) begin
      n = CNT_W'(depth);
    end
    return n;
  endfunction

  // round up to a multiple of eight, clamp to 8..65536
  function automatic logic [BYTES_W-1:0] eff_bytes(logic [BYTES_W-1:0] raw);
    logic [BYTES_W:0] r;
    r = ((BYTES_W+1)'(raw) + (BYTES_W+1)'(7)) & ~((BYTES_W+1)'(7));
    if (r == '0) begin
      r = (BYTES_W+1)'(8);
    end else if (r > (BYTES_W+1)'(MAX_CHUNK_BYTES)) begin
      r = (BYTES_W+1)'(MAX_CHUNK_BYTES);
    end
    return BYTES_W'(r);
  endfunction

endpackage

@@ design/fcpa_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module fcpa_ram #(
  parameter int WIDTH = fcpa_pkg::CNT_W,
  parameter int DEPTH = fcpa_pkg::DEF_POOL_DEPTH
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/fcpa_ctrl.sv @@
// Controller state machine: sequences allocate, free, and the relinking pass.
module fcpa_ctrl (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_operation,
  input  fcpa_pkg::stat_t       stat,
  output fcpa_pkg::cmd_t        cmd
);

  fcpa_pkg::state_e_t state_r, state_nxt;
  fcpa_pkg::op_e_t    op;
  logic               accept;

  assign op = fcpa_pkg::op_e_t'(in_operation);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= fcpa_pkg::S_SWEEP;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt       = state_r;
    in_ready        = 1'b0;
    accept          = 1'b0;
    cmd             = '0;
    cmd.resp_status = fcpa_pkg::ST_OK;
    case (state_r)
      fcpa_pkg::S_SWEEP: begin
        cmd.sweep_step = 1'b1;
        if (stat.sweep_last) begin
          state_nxt = fcpa_pkg::S_IDLE;
        end
      end
      fcpa_pkg::S_IDLE: begin
        in_ready = !stat.out_busy;
        accept   = in_valid && in_ready;
        if (accept) begin
          case (op)
            fcpa_pkg::OP_ALLOC: begin
              if (stat.size_bad) begin
                cmd.resp_load   = 1'b1;
                cmd.resp_status = fcpa_pkg::ST_TOO_BIG;
              end else if (stat.align_bad) begin
                cmd.resp_load   = 1'b1;
                cmd.resp_status = fcpa_pkg::ST_BAD_ALIGN;
              end else if (stat.empty) begin
                cmd.resp_load   = 1'b1;
                cmd.resp_status = fcpa_pkg::ST_NO_MEM;
              end else begin
                cmd.rd_issue = 1'b1;
                state_nxt    = fcpa_pkg::S_ALLOC;
              end
            end
            fcpa_pkg::OP_FREE: begin
              cmd.resp_load = 1'b1;
              if (stat.fidx_bad) begin
                cmd.resp_status = fcpa_pkg::ST_BAD_INDEX;
              end else begin
                cmd.free_push = 1'b1;
              end
            end
            fcpa_pkg::OP_RESET: begin
              // result goes out now; the pass then holds off new transfers
              cmd.resp_load   = 1'b1;
              cmd.sweep_start = 1'b1;
              state_nxt       = fcpa_pkg::S_SWEEP;
            end
            default: begin
              cmd.resp_load = 1'b1;
            end
          endcase
        end
      end
      fcpa_pkg::S_ALLOC: begin
        cmd.alloc_done = 1'b1;
        state_nxt      = fcpa_pkg::S_IDLE;
      end
      default: begin
        state_nxt = fcpa_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ design/fcpa_datapath.sv @@
// Datapath: head and count registers, link store, config, offset multiply, result register.
module fcpa_datapath #(
  parameter int POOL_DEPTH = fcpa_pkg::DEF_POOL_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [fcpa_pkg::SIZE_W-1:0]       in_request_size,
  input  logic [fcpa_pkg::ALIGN_W-1:0]      in_request_alignment,
  input  logic [fcpa_pkg::FIDX_W-1:0]       in_free_index,
  input  fcpa_pkg::cmd_t                    cmd,
  output fcpa_pkg::stat_t                   stat,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fcpa_pkg::OIDX_W-1:0]       out_chunk_index,
  output logic [fcpa_pkg::OFFSET_W-1:0]     out_byte_offset,
  output logic                              out_granted,
  output logic [fcpa_pkg::STATUS_W-1:0]     out_status,
  output logic [fcpa_pkg::CNT_W-1:0]        out_allocated_count
);

  localparam int IW    = $clog2(POOL_DEPTH);
  localparam int LW    = $clog2(POOL_DEPTH + 1);
  localparam int CMP_W = (LW > fcpa_pkg::CNT_W) ? LW : fcpa_pkg::CNT_W;
  localparam int PW    = IW + fcpa_pkg::BYTES_W;
  localparam logic [LW-1:0] NULL_LINK = LW'(POOL_DEPTH);
  localparam logic [IW-1:0] LAST_IDX  = IW'(POOL_DEPTH - 1);
  localparam logic [fcpa_pkg::CNT_W-1:0] DEPTH_COUNT =
    fcpa_pkg::eff_count(fcpa_pkg::RST_CHUNK_COUNT, POOL_DEPTH);
  localparam logic [fcpa_pkg::CNT_W-1:0] CNT_MAX = '1;

  logic [LW-1:0]                 head_r, head_nxt;
  logic [fcpa_pkg::CNT_W-1:0]    count_r, count_nxt;
  logic [fcpa_pkg::CNT_W-1:0]    eff_cnt_r;
  logic [fcpa_pkg::BYTES_W-1:0]  eff_bytes_r;
  logic [IW-1:0]                 sweep_idx_r;
  logic [fcpa_pkg::CNT_W-1:0]    sweep_n_r;
  logic [PW-1:0]                 prod_r;

  logic                          out_valid_r;
  logic [fcpa_pkg::OIDX_W-1:0]   out_idx_r;
  logic [fcpa_pkg::OFFSET_W-1:0] out_off_r;
  logic                          out_granted_r;
  logic [fcpa_pkg::STATUS_W-1:0] out_status_r;
  logic [fcpa_pkg::CNT_W-1:0]    out_count_r;

  logic                          ram_wr_en;
  logic [IW-1:0]                 ram_wr_addr;
  logic [LW-1:0]                 ram_wr_data;
  logic [LW-1:0]                 ram_rd_data;
  logic [LW-1:0]                 sweep_next;

  // checks on the item at the input ports, end of pass and result register full
  assign stat.size_bad   = in_request_size > eff_bytes_r;
  assign stat.align_bad  = in_request_alignment > fcpa_pkg::MAX_ALIGN;
  assign stat.empty      = head_r == NULL_LINK;
  assign stat.fidx_bad   = fcpa_pkg::CNT_W'(in_free_index) >= eff_cnt_r;
  assign stat.sweep_last = sweep_idx_r == LAST_IDX;
  assign stat.out_busy   = out_valid_r && !out_ready;

  // relink entry: i -> i+1 inside the pool, last one and any beyond it -> null
  assign sweep_next = ((CMP_W'(sweep_idx_r) + CMP_W'(1)) < CMP_W'(sweep_n_r)) ?
                      (LW'(sweep_idx_r) + LW'(1)) : NULL_LINK;

  always_comb begin
    ram_wr_en   = 1'b0;
    ram_wr_addr = sweep_idx_r;
    ram_wr_data = sweep_next;
    if (cmd.sweep_step) begin
      ram_wr_en = 1'b1;
    end else if (cmd.free_push) begin
      ram_wr_en   = 1'b1;
      ram_wr_addr = IW'(in_free_index);
      ram_wr_data = head_r;
    end
  end

  fcpa_ram #(
    .WIDTH (LW),
    .DEPTH (POOL_DEPTH)
  ) u_link_store (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (cmd.rd_issue),
    .rd_addr (head_r[IW-1:0]),
    .rd_data (ram_rd_data)
  );

  always_comb begin
    head_nxt  = head_r;
    count_nxt = count_r;
    if (cmd.sweep_start) begin
      head_nxt  = '0;
      count_nxt = '0;
    end else if (cmd.free_push) begin
      head_nxt  = LW'(in_free_index);
      count_nxt = (count_r == '0) ? count_r : count_r - fcpa_pkg::CNT_W'(1);
    end else if (cmd.alloc_done) begin
      head_nxt  = ram_rd_data;
      count_nxt = (count_r == CNT_MAX) ? count_r : count_r + fcpa_pkg::CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      count_r     <= '0;
      eff_cnt_r   <= DEPTH_COUNT;
      eff_bytes_r <= fcpa_pkg::RST_CHUNK_BYTES;
      sweep_idx_r <= '0;
      sweep_n_r   <= DEPTH_COUNT;
      out_valid_r <= 1'b0;
    end else begin
      head_r  <= head_nxt;
      count_r <= count_nxt;
      if (cfg_wr_en) begin
        case (fcpa_pkg::cfg_idx_e_t'(cfg_index))
          fcpa_pkg::CFG_CHUNK_COUNT:
            eff_cnt_r <= fcpa_pkg::eff_count(cfg_data[fcpa_pkg::CNT_W-1:0], POOL_DEPTH);
          fcpa_pkg::CFG_CHUNK_BYTES:
            eff_bytes_r <= fcpa_pkg::eff_bytes(cfg_data[fcpa_pkg::BYTES_W-1:0]);
          default: begin
          end
        endcase
      end
      // pool size for the pass is fixed at its start
      if (cmd.sweep_start) begin
        sweep_idx_r <= '0;
        sweep_n_r   <= eff_cnt_r;
      end else if (cmd.sweep_step) begin
        sweep_idx_r <= sweep_idx_r + IW'(1);
      end
      if (cmd.resp_load || cmd.alloc_done) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_issue) begin
      prod_r <= PW'(head_r[IW-1:0]) * PW'(eff_bytes_r);
    end
    if (cmd.alloc_done) begin
      out_idx_r     <= fcpa_pkg::OIDX_W'(head_r);
      out_off_r     <= fcpa_pkg::OFFSET_W'(prod_r);
      out_granted_r <= 1'b1;
      out_status_r  <= fcpa_pkg::ST_OK;
      out_count_r   <= count_nxt;
    end else if (cmd.resp_load) begin
      out_idx_r     <= '0;
      out_off_r     <= '0;
      out_granted_r <= 1'b0;
      out_status_r  <= cmd.resp_status;
      out_count_r   <= count_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_chunk_index     = out_idx_r;
  assign out_byte_offset     = out_off_r;
  assign out_granted         = out_granted_r;
  assign out_status          = out_status_r;
  assign out_allocated_count = out_count_r;

endmodule

@@ design/fixed_chunk_pool_allocator.sv @@
// Fixed-size chunk pool allocator with a linked free list held in a link store RAM.
// Allocate: a link-store read, then the head pop, which loads the result; no new request is
//   taken in between. Free, refused requests and the unused code load the result when taken.
//   Free one per cycle while each result is taken. Pool reset loads its result when taken,
//   then relinks the link store one entry per cycle, with no input transfer taken.
// After rst_n a relinking pass over all POOL_DEPTH entries runs before the first input
//   transfer; config writes are taken during it.
module fixed_chunk_pool_allocator #(
  parameter int POOL_DEPTH = fcpa_pkg::DEF_POOL_DEPTH
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [fcpa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [fcpa_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_operation,
  input  logic [fcpa_pkg::SIZE_W-1:0]       in_request_size,
  input  logic [fcpa_pkg::ALIGN_W-1:0]      in_request_alignment,
  input  logic [fcpa_pkg::FIDX_W-1:0]       in_free_index,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [fcpa_pkg::OIDX_W-1:0]       out_chunk_index,
  output logic [fcpa_pkg::OFFSET_W-1:0]     out_byte_offset,
  output logic                              out_granted,
  output logic [fcpa_pkg::STATUS_W-1:0]     out_status,
  output logic [fcpa_pkg::CNT_W-1:0]        out_allocated_count
);

  fcpa_pkg::cmd_t  cmd;
  fcpa_pkg::stat_t stat;

  fcpa_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_operation (in_operation),
    .stat         (stat),
    .cmd          (cmd)
  );

  fcpa_datapath #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_datapath (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg_wr_en            (cfg_wr_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data),
    .in_request_size      (in_request_size),
    .in_request_alignment (in_request_alignment),
    .in_free_index        (in_free_index),
    .cmd                  (cmd),
    .stat                 (stat),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_chunk_index      (out_chunk_index),
    .out_byte_offset      (out_byte_offset),
    .out_granted          (out_granted),
    .out_status           (out_status),
    .out_allocated_count  (out_allocated_count)
  );

  // a transfer is only taken when the result register has room
  a_accept_room: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |-> (!out_valid || out_ready))
    else $error("input transfer taken while result register full");

  // a link read is always followed by the head pop
  a_read_then_pop: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd_issue |=> cmd.alloc_done)
    else $error("allocate read not followed by pop");

  // relinking pass and a free never share the link store write port
  a_one_writer: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.sweep_step && (cmd.free_push || in_ready)))
    else $error("link store write conflict during relink");

  // a grant always reports ok
  a_grant_ok: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_granted) |-> (out_status == fcpa_pkg::ST_OK))
    else $error("granted result with error status");

endmodule
